FILE: src/plist_pkg.sv
// ============================================================================
// plist_pkg
// Shared widths, request codes, FSM states and structs for the positional list.
// ============================================================================
package plist_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 2;
    // common width for position / count range checks
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [KIND_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] REQ_LOCATE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_DOWN,
        ST_SCAN,
        ST_DONE
    } plist_state_t;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } plist_req_t;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] removed;
        logic [POS_W-1:0]         found;
        logic [POS_W-1:0]         length;
    } plist_res_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } plist_ram_ctl_t;

endpackage

FILE: src/plist_if.sv
// ============================================================================
// plist_if
// Valid/ready channel interfaces for list requests and results.
// ============================================================================
interface plist_req_if
    import plist_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        req_type;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] item_value;

    modport source (output valid, output req_type, output position, output item_value,
                    input ready);
    modport sink   (input valid, input req_type, input position, input item_value,
                    output ready);
endinterface

interface plist_rsp_if
    import plist_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] removed_value;
    logic [POS_W-1:0]         found_position;
    logic [POS_W-1:0]         list_length;

    modport source (output valid, output ok, output removed_value, output found_position,
                    output list_length, input ready);
    modport sink   (input valid, input ok, input removed_value, input found_position,
                    input list_length, output ready);
endinterface

FILE: src/plist_ram.sv
// ============================================================================
// plist_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module plist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/plist_engine.sv
// ============================================================================
// plist_engine
// Sequencer: shifts, deletes and scans the list one entry per cycle via the RAM.
// ============================================================================
module plist_engine
    import plist_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  plist_req_t        req,
    output logic              idle,
    output logic              res_valid,
    input  logic              res_take,
    output plist_res_t        res,
    output plist_ram_ctl_t    ram_ctl,
    input  logic [DATA_W-1:0] rd_data
);

    plist_state_t             state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         idx_reg, idx_next;
    logic [ADDR_W-1:0]        posm1_reg, posm1_next;
    logic [DATA_W-1:0]        val_reg, val_next;
    logic                     pend_reg, pend_next;
    logic [ADDR_W-1:0]        pend_addr_reg, pend_addr_next;
    logic                     first_reg, first_next;
    logic                     grab_reg, grab_next;
    logic                     ok_reg, ok_next;
    logic [DATA_W-1:0]        removed_reg, removed_next;
    logic [POS_W-1:0]         found_reg, found_next;

    logic [CMP_W-1:0]         pos_ext, pos_m1_ext, cnt_ext;
    logic [CNT_W-1:0]         idx_m1, idx_p1, found_ext;
    logic                     ins_ok, del_ok;
    logic                     up_more, up_end, dn_more, dn_end;
    logic                     sc_hit, sc_more;

    // range checks and loop conditions
    assign pos_ext    = CMP_W'(req.pos);
    assign pos_m1_ext = pos_ext - 1'b1;
    assign cnt_ext    = CMP_W'(cnt_reg);
    assign ins_ok     = (pos_ext != '0) && (pos_ext <= cnt_ext + 1'b1)
                        && (cnt_reg < CNT_W'(CAPACITY));
    assign del_ok     = (pos_ext != '0) && (pos_ext <= cnt_ext);

    assign idx_m1     = idx_reg - 1'b1;
    assign idx_p1     = idx_reg + 1'b1;
    assign found_ext  = CNT_W'(pend_addr_reg) + 1'b1;

    assign up_more    = idx_reg > CNT_W'(posm1_reg);
    assign up_end     = !up_more && !pend_reg;
    assign dn_more    = idx_reg < cnt_reg;
    assign dn_end     = !dn_more && !pend_reg && !grab_reg;
    // the one shared comparator: stored entry against the search value
    assign sc_hit     = pend_reg && (rd_data == val_reg);
    assign sc_more    = idx_reg < cnt_reg;

    assign idle       = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);
    assign res.ok      = ok_reg;
    assign res.removed = removed_reg;
    assign res.found   = found_reg;
    assign res.length  = POS_W'(cnt_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req.kind == REQ_INSERT && ins_ok)
                    begin
                        state_next = ST_UP;
                    end
                    else if (req.kind == REQ_DELETE && del_ok)
                    begin
                        state_next = ST_DOWN;
                    end
                    else if (req.kind == REQ_LOCATE)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_UP:
            begin
                if (up_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DOWN:
            begin
                if (dn_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (sc_hit || !sc_more)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        posm1_next     = posm1_reg;
        val_next       = val_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        first_next     = first_reg;
        grab_next      = grab_reg;
        ok_next        = ok_reg;
        removed_next   = removed_reg;
        found_next     = found_reg;
        ram_ctl.we      = 1'b0;
        ram_ctl.wr_addr = pend_addr_reg;
        ram_ctl.wr_data = rd_data;
        ram_ctl.rd_addr = idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ok_next      = 1'b0;
                    removed_next = '0;
                    found_next   = '0;
                    pend_next    = 1'b0;
                    grab_next    = 1'b0;
                    first_next   = 1'b1;
                    val_next     = req.value;
                    posm1_next   = pos_m1_ext[ADDR_W-1:0];
                    if (req.kind == REQ_INSERT)
                    begin
                        idx_next = cnt_reg;
                    end
                    else if (req.kind == REQ_DELETE)
                    begin
                        idx_next = CNT_W'(pos_m1_ext);
                    end
                    else
                    begin
                        idx_next = '0;
                    end
                end
            end
            ST_UP:
            begin
                // move entry idx-1 to idx, top down; then drop the new value in
                ram_ctl.rd_addr = idx_m1[ADDR_W-1:0];
                ram_ctl.we      = pend_reg;
                if (up_end)
                begin
                    ram_ctl.we      = 1'b1;
                    ram_ctl.wr_addr = posm1_reg;
                    ram_ctl.wr_data = val_reg;
                    ok_next         = 1'b1;
                    cnt_next        = cnt_reg + 1'b1;
                end
                if (up_more)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[ADDR_W-1:0];
                    idx_next       = idx_m1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ST_DOWN:
            begin
                // first read returns the removed entry, later ones slide down
                ram_ctl.we = pend_reg;
                if (grab_reg)
                begin
                    removed_next = rd_data;
                end
                if (dn_more)
                begin
                    grab_next      = first_reg;
                    pend_next      = !first_reg;
                    pend_addr_next = idx_m1[ADDR_W-1:0];
                    idx_next       = idx_p1;
                    first_next     = 1'b0;
                end
                else
                begin
                    grab_next = 1'b0;
                    pend_next = 1'b0;
                end
                if (dn_end)
                begin
                    ok_next  = 1'b1;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (sc_hit)
                begin
                    ok_next    = 1'b1;
                    found_next = POS_W'(found_ext);
                    pend_next  = 1'b0;
                end
                else if (sc_more)
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[ADDR_W-1:0];
                    idx_next       = idx_p1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            grab_reg  <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            grab_reg  <= grab_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        posm1_reg     <= posm1_next;
        val_reg       <= val_next;
        pend_addr_reg <= pend_addr_next;
        ok_reg        <= ok_next;
        removed_reg   <= removed_next;
        found_reg     <= found_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_cnt_at_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> (state_reg == ST_DONE))
        else $error("entry count changed outside completion");

    a_write_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        ram_ctl.we |-> (state_reg == ST_UP || state_reg == ST_DOWN))
        else $error("RAM write outside a shift");

    a_grab_in_delete: assert property (@(posedge clk) disable iff (!rst_n)
        grab_reg |-> (state_reg == ST_DOWN))
        else $error("removed-value capture outside delete");

endmodule

FILE: src/positional_list_insert_delete_search.sv
// ============================================================================
// positional_list_insert_delete_search
// Ordered list of signed 32-bit values: insert/delete at position, locate.
// ============================================================================
//
//  Channel | Dir | Handshake    | Transaction payload
//  --------+-----+--------------+------------------------------------------------
//  req     | in  | valid/ready  | req_type, position, item_value
//  rsp     | out | valid/ready  | ok, removed_value, found_position, list_length
//
//  After an accept, req.ready stays low while the engine moves or compares
//    one entry per cycle through the single-write, single-read RAM: an insert
//    shifts the entries from the position up, a delete shifts those above it
//    down, a locate scans from the front until a hit or the end; rejects
//    go straight to the result.
//  req.ready is high only while the engine is idle; one transaction at a time.
//  One result can wait in the output register while the engine frees up; while
//    that register stays full the engine holds the next result and stays busy.
//  Reset clears the count and control state only; the entry RAM is not cleared.
//
module positional_list_insert_delete_search
    import plist_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    plist_req_if.sink   req,
    plist_rsp_if.source rsp
);

    plist_req_t        eng_req;
    plist_res_t        eng_res;
    plist_ram_ctl_t    ram_ctl;
    logic [DATA_W-1:0] ram_rd_data;
    logic              eng_idle;
    logic              eng_res_valid;
    logic              res_load;

    logic              out_valid_reg, out_valid_next;
    plist_res_t        out_res_reg;

    // request pass-through into the engine struct
    assign eng_req.kind  = req.req_type;
    assign eng_req.pos   = req.position;
    assign eng_req.value = req.item_value;
    assign req.ready     = eng_idle;

    // output stage: load when empty or being drained
    assign res_load = eng_res_valid && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_res_reg <= eng_res;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = out_res_reg.ok;
    assign rsp.removed_value  = out_res_reg.removed;
    assign rsp.found_position = out_res_reg.found;
    assign rsp.list_length    = out_res_reg.length;

    plist_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (req.valid && eng_idle),
        .req       (eng_req),
        .idle      (eng_idle),
        .res_valid (eng_res_valid),
        .res_take  (res_load),
        .res       (eng_res),
        .ram_ctl   (ram_ctl),
        .rd_data   (ram_rd_data)
    );

    // entry store
    plist_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk     (clk),
        .we      (ram_ctl.we),
        .wr_addr (ram_ctl.wr_addr),
        .wr_data (ram_ctl.wr_data),
        .rd_addr (ram_ctl.rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

FILE: sim/plist_check.sv
`timescale 1ns / 100ps
// ============================================================================
// plist_check
// Watches the request and result channels of the positional list, keeps its
// own copy of the list, works out the result of every accepted request and
// compares each accepted result with the oldest one still owed.
// ============================================================================
module plist_check
    import plist_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    plist_req_if        req,
    plist_rsp_if        rsp,
    output int unsigned mismatches,
    output int unsigned open_count,
    output int unsigned list_len
);

    logic signed [DATA_W-1:0] list_mirror[$];
    plist_res_t               owed_results[$];
    plist_req_t               taken;
    plist_res_t               want;
    plist_res_t               got;
    int unsigned              fails;

    // Applies one request to the mirror and returns the result it must give.
    function automatic plist_res_t apply_list_request(input plist_req_t r);
        plist_res_t res;
        int         p;
        int         k;
        res = '0;
        p   = r.pos;
        case (r.kind)
            REQ_INSERT:
                if (p >= 1 && p <= list_mirror.size() + 1 && list_mirror.size() < CAPACITY)
                begin
                    list_mirror.insert(p - 1, r.value);
                    res.ok = 1'b1;
                end
            REQ_DELETE:
                if (p >= 1 && p <= list_mirror.size())
                begin
                    res.removed = list_mirror[p - 1];
                    list_mirror.delete(p - 1);
                    res.ok = 1'b1;
                end
            REQ_LOCATE:
            begin
                k = 0;
                while (!res.ok && k < list_mirror.size())
                begin
                    if (list_mirror[k] == r.value)
                    begin
                        res.ok    = 1'b1;
                        res.found = POS_W'(k + 1);
                    end
                    k++;
                end
            end
            default:
                res.ok = 1'b0;  // unused code: no effect
        endcase
        res.length = POS_W'(list_mirror.size());
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_mirror.delete();
            owed_results.delete();
            fails      = 0;
            mismatches <= 0;
            open_count <= 0;
            list_len   <= 0;
        end
        else
        begin
            // result first: it always belongs to an earlier request
            if (rsp.valid && rsp.ready)
            begin
                got.ok      = rsp.ok;
                got.removed = rsp.removed_value;
                got.found   = rsp.found_position;
                got.length  = rsp.list_length;
                if (owed_results.size() == 0)
                begin
                    $error("result transaction with none expected: ok %0d removed_value %0d",
                           got.ok, got.removed);
                    fails++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (got.ok !== want.ok)
                    begin
                        $error("ok: expected %0d, got %0d", want.ok, got.ok);
                        fails++;
                    end
                    if (got.removed !== want.removed)
                    begin
                        $error("removed_value: expected %0d, got %0d", want.removed, got.removed);
                        fails++;
                    end
                    if (got.found !== want.found)
                    begin
                        $error("found_position: expected %0d, got %0d", want.found, got.found);
                        fails++;
                    end
                    if (got.length !== want.length)
                    begin
                        $error("list_length: expected %0d, got %0d", want.length, got.length);
                        fails++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                taken.kind  = req.req_type;
                taken.pos   = req.position;
                taken.value = req.item_value;
                owed_results.push_back(apply_list_request(taken));
            end
            mismatches <= fails;
            open_count <= owed_results.size();
            list_len   <= list_mirror.size();
        end
    end

endmodule

FILE: sim/tb_positional_list_insert_delete_search.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_positional_list_insert_delete_search
// Drives insert, delete and locate requests into the positional list and lets
// plist_check judge every result transaction. A directed opening covers the
// value extremes, every request kind and each rejection but a full list; random
// phases then grow the list to full, shrink it and mix requests under varying
// idle rates on both channels; one long result stall backs up the request side.
// ============================================================================
module tb_positional_list_insert_delete_search;
    import plist_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 9;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int RSP_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES     = CAPACITY + 16;
    localparam int GROW_MAX        = 120;
    localparam int FULL_EXTRA      = 6;
    localparam int SHRINK_ITEMS    = 40;
    localparam int EVEN_ITEMS      = 45;
    localparam int BURST_ITEMS     = 10;

    // Code 3 is outside the three request kinds; the block must ignore it.
    localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

    // request mix of a random phase
    typedef enum logic [1:0] {
        MIX_GROW,
        MIX_SHRINK,
        MIX_EVEN
    } req_mix_t;

    // Small pool of repeating values so locates hit, often on duplicates.
    localparam int POOL_N = 8;
    logic signed [DATA_W-1:0] value_pool[POOL_N] =
        '{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 32'sd0, 32'sd1, 32'sd42,
          -32'sd77, 32'sh5A5A_A5A5};

    logic        clk = 1'b0;
    logic        rst_n;
    int          send_idle_pct = 23;
    int          recv_idle_pct = 57;
    int unsigned holds_asked = 0;
    int unsigned holds_done  = 0;
    int unsigned cycle_count = 0;
    int unsigned check_fails;
    int unsigned owed;
    int unsigned model_len;

    plist_req_if req ();
    plist_rsp_if rsp ();

    positional_list_insert_delete_search dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    plist_check check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .mismatches (check_fails),
        .open_count (owed),
        .list_len   (model_len)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side ready. Normally random per cycle; when the stimulus asks for a
    // hold, ready stays low for a long stretch counted here so the block backs up.
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                rsp.ready <= 1'b0;
            else if (holds_done != holds_asked)
            begin
                rsp.ready <= 1'b0;
                repeat (RSP_HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
                rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offers one request transaction and returns at the edge where it is taken.
    // valid is left high; the next call drops it only for its random idle gaps.
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                                input logic signed [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.req_type   <= kind;
        req.position   <= pos;
        req.item_value <= value;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // Sender goes quiet until every owed result transaction is back.
    task automatic drain_results();
        req.valid <= 1'b0;
        @(posedge clk);
        while (owed != 0)
            @(posedge clk);
    endtask

    // Mostly in-range positions, biased to the front and back ends; some fully
    // random ones to hit the rejects and toggle every position bit.
    function automatic logic [POS_W-1:0] pick_position(input int last_pos);
        int roll;
        roll = $urandom_range(99);
        if (roll < 15)
            return POS_W'($urandom_range(127));
        if (roll < 30)
            return POS_W'(1);
        if (roll < 45)
            return POS_W'(last_pos);
        return POS_W'($urandom_range(last_pos, 1));
    endfunction

    function automatic plist_req_t pick_request(input req_mix_t mix, input int len);
        plist_req_t r;
        int         w_ins;
        int         w_del;
        int         w_loc;
        int         roll;
        unique case (mix)
            MIX_GROW:
            begin
                w_ins = 85;
                w_del = 5;
                w_loc = 8;
            end
            MIX_SHRINK:
            begin
                w_ins = 15;
                w_del = 70;
                w_loc = 12;
            end
            default:
            begin
                w_ins = 35;
                w_del = 30;
                w_loc = 32;
            end
        endcase
        if ($urandom_range(99) < 55)
            r.value = value_pool[$urandom_range(POOL_N - 1)];
        else
            r.value = $urandom;
        roll = $urandom_range(99);
        if (roll < w_ins)
        begin
            r.kind = REQ_INSERT;
            r.pos  = pick_position(len + 1);
        end
        else if (roll < w_ins + w_del)
        begin
            r.kind = REQ_DELETE;
            r.pos  = pick_position((len == 0) ? 1 : len);
        end
        else
        begin
            r.kind = (roll < w_ins + w_del + w_loc) ? REQ_LOCATE : REQ_UNUSED;
            r.pos  = POS_W'($urandom_range(127));
        end
        return r;
    endfunction

    task automatic send_random(input req_mix_t mix);
        plist_req_t r;
        r = pick_request(mix, model_len);
        send_request(r.kind, r.pos, r.value);
    endtask

    initial
    begin
        int grown;
        int extra;
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.req_type   = REQ_INSERT;
        req.position   = '0;
        req.item_value = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed opening ---
        // empty list: locate misses, delete and bad inserts are rejected
        send_request(REQ_LOCATE, 7'd0,   32'sd0);
        send_request(REQ_DELETE, 7'd1,   32'sd0);
        send_request(REQ_INSERT, 7'd0,   32'sd5);
        send_request(REQ_INSERT, 7'd2,   32'sd5);
        // build [MIN, -1, 0, MAX, -1]: front, back and middle inserts
        send_request(REQ_INSERT, 7'd1,   VAL_MAX);
        send_request(REQ_INSERT, 7'd1,   VAL_MIN);
        send_request(REQ_INSERT, 7'd3,   -32'sd1);
        send_request(REQ_INSERT, 7'd2,   32'sd0);
        send_request(REQ_INSERT, 7'd127, 32'sd1);
        send_request(REQ_INSERT, 7'd2,   -32'sd1);
        // locate: first of two matches, both extremes, a miss
        send_request(REQ_LOCATE, 7'd127, -32'sd1);
        send_request(REQ_LOCATE, 7'd0,   VAL_MIN);
        send_request(REQ_LOCATE, 7'd64,  VAL_MAX);
        send_request(REQ_LOCATE, 7'd1,   32'sd42);
        send_request(REQ_UNUSED, 7'd1,   32'sd5);
        // delete rejects at position zero, one past the end and the top code
        send_request(REQ_DELETE, 7'd0,   32'sd0);
        send_request(REQ_DELETE, 7'd6,   32'sd0);
        send_request(REQ_DELETE, 7'd127, VAL_MAX);
        // delete back, front, middle, then down to empty
        send_request(REQ_DELETE, 7'd5,   32'sd0);
        send_request(REQ_DELETE, 7'd1,   32'sd0);
        send_request(REQ_DELETE, 7'd2,   32'sd0);
        send_request(REQ_DELETE, 7'd2,   32'sd0);
        send_request(REQ_DELETE, 7'd1,   32'sd0);
        send_request(REQ_DELETE, 7'd1,   32'sd0);
        send_request(REQ_LOCATE, 7'd3,   -32'sd1);
        drain_results();

        // --- back-pressure: stall results while requests keep coming ---
        holds_asked   <= holds_asked + 1;
        send_idle_pct = 0;
        repeat (BURST_ITEMS) send_random(MIX_GROW);
        drain_results();

        // --- random phases under three idle settings ---
        for (int phase = 0; phase < 3; phase++)
        begin
            unique case (phase)
                0:
                begin
                    send_idle_pct = 23;
                    recv_idle_pct <= 57;
                end
                1:
                begin
                    send_idle_pct = 57;
                    recv_idle_pct <= 23;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            // grow until full, then a few more to hit the full-list rejects
            grown = 0;
            extra = 0;
            while (grown < GROW_MAX && extra < FULL_EXTRA)
            begin
                if (model_len >= CAPACITY)
                    extra++;
                send_random(MIX_GROW);
                grown++;
            end
            repeat (SHRINK_ITEMS) send_random(MIX_SHRINK);
            repeat (EVEN_ITEMS) send_random(MIX_EVEN);
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (check_fails == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: positional_list_insert_delete_search.f
src/plist_pkg.sv
src/plist_if.sv
src/plist_ram.sv
src/plist_engine.sv
src/positional_list_insert_delete_search.sv
sim/plist_check.sv
sim/tb_positional_list_insert_delete_search.sv
